// File: rtl/jac_pkg.sv
// Shared types and constants for the JPEG APP1/COM segment extractor.
`default_nettype none
package jac_pkg;

  localparam int unsigned TOTAL_W   = 21;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam int unsigned DEF_MAX_SEGMENTS = 16;

  // command queue between parser and result stage
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // marker bytes
  localparam logic [7:0] MK_FF   = 8'hFF;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_EOI  = 8'hD9;
  localparam logic [7:0] MK_SOS  = 8'hDA;
  localparam logic [7:0] MK_ZERO = 8'h00;
  localparam logic [7:0] MK_APP1 = 8'hE1;
  localparam logic [7:0] MK_COM  = 8'hFE;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         out_byte;
    logic [TOTAL_W-1:0] total_size;
    logic               last_of_run;
  } out_item_t;

  // one queue entry: the one or two results caused by one input item
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } cmd_t;

  function automatic out_item_t mk_res(input logic [1:0] kind, input logic [7:0] b,
                                       input logic [TOTAL_W-1:0] total);
    out_item_t r;
    r.kind        = kind;
    r.out_byte    = b;
    r.total_size  = total;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/jpeg_app1_com_segment_extractor.sv
// Top level of the JPEG APP1/COM segment extractor.
`default_nettype none
// Takes a JPEG buffer one byte per item (in_push/in_full) and streams out the
// bytes of the first MAX_SEGMENTS APP1 and COM segments (marker, code, both
// length bytes and payload), followed by one verdict item: success with the
// total copied byte count, or failure, after which the consumer should drop
// what it received. Every result belonging to one input byte comes out in a
// row, and the final one carries last_of_run. The byte after the one marked
// end_of_buffer starts a fresh buffer. A byte is accepted every cycle as
// long as the 4-entry command queue between the parser and the result stage
// has room; in_full rises when that queue fills, which happens when results
// are popped more slowly than the incoming bytes produce them. A byte causes
// at most two results; the result stage hands out one per cycle while the
// consumer pops, so sustained throughput is one byte per cycle while segments
// are skipped or copied byte by byte, and drops below that for the bytes that
// cause two results: the code of a copied APP1/COM segment, and a copied
// length or payload byte on which the scan fails. The command of a byte is
// registered in the command queue and then in the result stage's output
// register before its first result can be popped. There is no configuration
// and no start-up sweep: the block is ready right after reset.
module jpeg_app1_com_segment_extractor #(
  parameter int unsigned MAX_SEGMENTS = jac_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire jac_pkg::in_item_t  in_item,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output jac_pkg::out_item_t      out_item
);

  logic          in_acc;
  jac_pkg::cmd_t f_cmd;
  logic          f_cmd_valid;
  jac_pkg::cmd_t q_dout;
  logic          q_empty;
  logic          q_take;

  assign in_acc = in_push && !in_full;

  // parser: classifies each byte and emits a command for its results
  jac_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .item     (in_item),
    .cmd      (f_cmd),
    .cmd_valid(f_cmd_valid)
  );

  // decouples the parser from a stalled consumer
  jac_cmd_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (f_cmd_valid),
    .din  (f_cmd),
    .pop  (q_take),
    .dout (q_dout),
    .full (in_full),
    .empty(q_empty)
  );

  // output register plus one pending slot for the second result
  jac_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(!q_empty),
    .cmd      (q_dout),
    .cmd_take (q_take),
    .pop      (out_pop),
    .empty    (out_empty),
    .item     (out_item)
  );

  // a verdict always closes its run
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.kind != jac_pkg::KIND_BYTE |-> out_item.last_of_run)
    else $error("verdict result without last_of_run");

  // the rest of a run follows right after a popped non-final result
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop && !out_item.last_of_run |=> !out_empty)
    else $error("run broken after non-final result");

  // verdicts carry no byte, only success carries a count
  a_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.kind != jac_pkg::KIND_BYTE |->
      out_item.out_byte == 8'd0 &&
      (out_item.kind == jac_pkg::KIND_OK || out_item.total_size == '0))
    else $error("verdict result carries stray data");

endmodule
`default_nettype wire

// File: rtl/jac_front.sv
// Byte parser: marker/length state machine producing result commands.
`default_nettype none
module jac_front #(
  parameter int unsigned MAX_SEGMENTS = jac_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire jac_pkg::in_item_t item,
  output jac_pkg::cmd_t         cmd,
  output logic                  cmd_valid
);

  localparam int unsigned SEG_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned TW    = jac_pkg::TOTAL_W;

  localparam logic [2:0] PH_SOI0 = 3'd0;
  localparam logic [2:0] PH_SOI1 = 3'd1;
  localparam logic [2:0] PH_HUNT = 3'd2;
  localparam logic [2:0] PH_CODE = 3'd3;
  localparam logic [2:0] PH_LENH = 3'd4;
  localparam logic [2:0] PH_LENL = 3'd5;
  localparam logic [2:0] PH_BODY = 3'd6;
  localparam logic [2:0] PH_DONE = 3'd7;

  logic [2:0]       phase_r, phase_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic             copy_r, copy_nxt;
  logic [SEG_W-1:0] segs_r, segs_nxt;
  logic [TW-1:0]    total_r, total_nxt;
  logic [7:0]       lenh_r, lenh_nxt;

  logic [7:0]  b;
  logic        last;
  logic        emit_pair, emit_byte, emit_ok, emit_fail;
  logic [15:0] len;
  logic [TW:0] sum;
  logic [1:0]  cnt;
  logic [1:0]  vkind;
  logic [TW-1:0] vtotal;

  assign b    = item.data_byte;
  assign last = item.end_of_buffer;
  assign len  = {lenh_r, b};
  assign sum  = {1'b0, total_r} + (TW+1)'(len) + (TW+1)'(2);

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    copy_nxt  = copy_r;
    segs_nxt  = segs_r;
    total_nxt = total_r;
    lenh_nxt  = lenh_r;
    emit_pair = 1'b0;
    emit_byte = 1'b0;
    emit_ok   = 1'b0;
    emit_fail = 1'b0;
    case (phase_r)
      PH_SOI0: begin
        if (b != jac_pkg::MK_FF || last) emit_fail = 1'b1;
        else phase_nxt = PH_SOI1;
      end
      PH_SOI1: begin
        if (b != jac_pkg::MK_SOI || last) emit_fail = 1'b1;
        else phase_nxt = PH_HUNT;
      end
      PH_HUNT: begin
        if (last) emit_fail = 1'b1;
        else if (b == jac_pkg::MK_FF) phase_nxt = PH_CODE;
      end
      PH_CODE: begin
        if (b == jac_pkg::MK_FF) begin
          if (last) emit_fail = 1'b1;
        end else if (b inside {jac_pkg::MK_EOI, jac_pkg::MK_SOS, jac_pkg::MK_ZERO}) begin
          emit_ok = 1'b1;
        end else if (last) begin
          emit_fail = 1'b1;
        end else begin
          copy_nxt = 1'b0;
          if ((b == jac_pkg::MK_APP1 || b == jac_pkg::MK_COM) &&
              segs_r < SEG_W'(MAX_SEGMENTS)) begin
            copy_nxt  = 1'b1;
            segs_nxt  = segs_r + SEG_W'(1);
            emit_pair = 1'b1;
          end
          phase_nxt = PH_LENH;
        end
      end
      PH_LENH: begin
        emit_byte = copy_r;
        lenh_nxt  = b;
        if (last) emit_fail = 1'b1;
        else phase_nxt = PH_LENL;
      end
      PH_LENL: begin
        emit_byte = copy_r;
        if (len < 16'd2 || last) begin
          emit_fail = 1'b1;
        end else begin
          if (copy_r) total_nxt = sum[TW] ? jac_pkg::TOTAL_MAX : sum[TW-1:0];
          rem_nxt   = len - 16'd2;
          phase_nxt = (len == 16'd2) ? PH_HUNT : PH_BODY;
        end
      end
      PH_BODY: begin
        emit_byte = copy_r;
        if (last) begin
          emit_fail = 1'b1;
        end else begin
          rem_nxt = rem_r - 16'd1;
          if (rem_r == 16'd1) phase_nxt = PH_HUNT;
        end
      end
      default: ;
    endcase
    if (emit_fail || emit_ok) phase_nxt = PH_DONE;
    // the last byte of a buffer restarts the parser
    if (last) begin
      phase_nxt = PH_SOI0;
      rem_nxt   = '0;
      copy_nxt  = 1'b0;
      segs_nxt  = '0;
      total_nxt = '0;
      lenh_nxt  = '0;
    end
  end

  // pack results into a command
  always_comb begin
    vkind  = emit_ok ? jac_pkg::KIND_OK : jac_pkg::KIND_FAIL;
    vtotal = emit_ok ? total_r : '0;
    cmd.r0 = jac_pkg::mk_res(jac_pkg::KIND_BYTE, b, '0);
    cmd.r1 = jac_pkg::mk_res(vkind, 8'd0, vtotal);
    cnt    = 2'd0;
    if (emit_pair) begin
      cmd.r0 = jac_pkg::mk_res(jac_pkg::KIND_BYTE, jac_pkg::MK_FF, '0);
      cmd.r1 = jac_pkg::mk_res(jac_pkg::KIND_BYTE, b, '0);
      cnt    = 2'd2;
    end else if (emit_byte) begin
      cnt = (emit_ok || emit_fail) ? 2'd2 : 2'd1;
    end else if (emit_ok || emit_fail) begin
      cmd.r0 = jac_pkg::mk_res(vkind, 8'd0, vtotal);
      cnt    = 2'd1;
    end
    cmd.two = (cnt == 2'd2);
    if (cnt == 2'd2) cmd.r1.last_of_run = 1'b1;
    else cmd.r0.last_of_run = 1'b1;
    cmd_valid = accept && (cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SOI0;
      rem_r   <= '0;
      copy_r  <= 1'b0;
      segs_r  <= '0;
      total_r <= '0;
      lenh_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      copy_r  <= copy_nxt;
      segs_r  <= segs_nxt;
      total_r <= total_nxt;
      lenh_r  <= lenh_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/jac_cmd_fifo.sv
// Small command queue between the parser and the result stage.
`default_nettype none
module jac_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire jac_pkg::cmd_t din,
  input  wire logic          pop,
  output jac_pkg::cmd_t      dout,
  output logic               full,
  output logic               empty
);

  jac_pkg::cmd_t          q_r [jac_pkg::QDEPTH];
  logic [jac_pkg::QAW-1:0] wp_r, rp_r;
  logic [jac_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  assign full    = (cnt_r == (jac_pkg::QAW+1)'(jac_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (jac_pkg::QAW+1)'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - (jac_pkg::QAW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + jac_pkg::QAW'(1);
      if (do_pop) rp_r <= rp_r + jac_pkg::QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/jac_back.sv
// Result stage: expands commands into single results, one per pop.
`default_nettype none
module jac_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire jac_pkg::cmd_t cmd,
  output logic               cmd_take,
  input  wire logic          pop,
  output logic               empty,
  output jac_pkg::out_item_t item
);

  logic               hold_v_r, hold_v_nxt;
  logic               pend_v_r, pend_v_nxt;
  jac_pkg::out_item_t hold_r, hold_nxt;
  jac_pkg::out_item_t pend_r, pend_nxt;
  logic               pop_acc;

  assign empty    = !hold_v_r;
  assign item     = hold_r;
  assign pop_acc  = pop && hold_v_r;
  assign cmd_take = cmd_valid && (!hold_v_r || (pop_acc && !pend_v_r));

  always_comb begin
    hold_v_nxt = hold_v_r;
    pend_v_nxt = pend_v_r;
    hold_nxt   = hold_r;
    pend_nxt   = pend_r;
    if (pop_acc) begin
      if (pend_v_r) begin
        hold_nxt   = pend_r;
        pend_v_nxt = 1'b0;
      end else begin
        hold_v_nxt = 1'b0;
      end
    end
    if (cmd_take) begin
      hold_nxt   = cmd.r0;
      hold_v_nxt = 1'b1;
      pend_nxt   = cmd.r1;
      pend_v_nxt = cmd.two;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

endmodule
`default_nettype wire
